FILE: hdl/mvd_pkg.sv
// Shared types and constants for the MessagePack value delimiter.
package mvd_pkg;

    localparam int PENDING_WIDTH_DEF = 32;
    localparam int LEN_ACC_W         = 32;
    localparam int SKIP_W            = 32;
    localparam int LEN_LEFT_W        = 3;
    localparam int SMALL_W           = 5;

    typedef enum logic [1:0] {
        KIND_RAW,
        KIND_EXT,
        KIND_ARR,
        KIND_MAP
    } t_kind;

    typedef enum logic [1:0] {
        ROLE_TAG,
        ROLE_LEN,
        ROLE_EXT,
        ROLE_PAY
    } t_role;

    typedef enum logic [1:0] {
        ACT_DONE,
        ACT_ADD,
        ACT_SKIP,
        ACT_LEN
    } t_action;

    // Decoded tag byte
    typedef struct packed {
        t_action               act;
        logic                  skip_to_ext;
        t_kind                 kind;
        logic [LEN_LEFT_W-1:0] nbytes;
        logic [SMALL_W-1:0]    cnt;
    } t_tag_info;

    typedef struct packed {
        t_role role;
        logic  value_end;
        logic  error_code;
    } t_result;

endpackage

FILE: hdl/mvd_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
interface mvd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface mvd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] byte_role;
    logic       value_end;
    logic       error_code;

    modport source (output valid, output byte_role, output value_end, output error_code,
                    input ready);
    modport sink   (input valid, input byte_role, input value_end, input error_code,
                    output ready);
endinterface

FILE: hdl/mvd_tag_decode.sv
// Tag byte decoder: maps a MessagePack tag to the action it starts.
module mvd_tag_decode (
    input  logic               [7:0] i_byte,
    output mvd_pkg::t_tag_info       o_info
);
    import mvd_pkg::*;

    always_comb begin
        o_info             = '0;
        o_info.act         = ACT_DONE;
        o_info.kind        = KIND_RAW;
        o_info.skip_to_ext = 1'b0;
        unique case (i_byte) inside
            [8'h00:8'h7f], [8'hc0:8'hc3], [8'he0:8'hff]: begin
                o_info.act = ACT_DONE;
            end
            [8'h80:8'h8f]: begin
                o_info.act = ACT_ADD;
                o_info.cnt = {i_byte[3:0], 1'b0};
            end
            [8'h90:8'h9f]: begin
                o_info.act = ACT_ADD;
                o_info.cnt = {1'b0, i_byte[3:0]};
            end
            [8'ha0:8'hbf]: begin
                o_info.act = ACT_SKIP;
                o_info.cnt = i_byte[4:0];
            end
            [8'hc4:8'hc6]: begin
                o_info.act    = ACT_LEN;
                o_info.kind   = KIND_RAW;
                o_info.nbytes = LEN_LEFT_W'(1) << 2'(i_byte - 8'hc4);
            end
            [8'hc7:8'hc9]: begin
                o_info.act    = ACT_LEN;
                o_info.kind   = KIND_EXT;
                o_info.nbytes = LEN_LEFT_W'(1) << 2'(i_byte - 8'hc7);
            end
            8'hca: begin
                o_info.act = ACT_SKIP;
                o_info.cnt = SMALL_W'(4);
            end
            8'hcb: begin
                o_info.act = ACT_SKIP;
                o_info.cnt = SMALL_W'(8);
            end
            [8'hcc:8'hcf]: begin
                o_info.act = ACT_SKIP;
                o_info.cnt = SMALL_W'(1) << 2'(i_byte - 8'hcc);
            end
            [8'hd0:8'hd3]: begin
                o_info.act = ACT_SKIP;
                o_info.cnt = SMALL_W'(1) << 2'(i_byte - 8'hd0);
            end
            [8'hd4:8'hd8]: begin
                // fixext: type byte, then 1..16 data bytes
                o_info.act         = ACT_SKIP;
                o_info.skip_to_ext = 1'b1;
                o_info.cnt         = SMALL_W'(1) << 3'(i_byte - 8'hd4);
            end
            [8'hd9:8'hdb]: begin
                o_info.act    = ACT_LEN;
                o_info.kind   = KIND_RAW;
                o_info.nbytes = LEN_LEFT_W'(1) << 2'(i_byte - 8'hd9);
            end
            [8'hdc:8'hdd]: begin
                o_info.act    = ACT_LEN;
                o_info.kind   = KIND_ARR;
                o_info.nbytes = LEN_LEFT_W'(2) << 1'(i_byte - 8'hdc);
            end
            default: begin
                // map16 / map32
                o_info.act    = ACT_LEN;
                o_info.kind   = KIND_MAP;
                o_info.nbytes = LEN_LEFT_W'(2) << 1'(i_byte - 8'hde);
            end
        endcase
    end

endmodule

FILE: hdl/mvd_parser.sv
// Parse state registers and the per-byte next-state and result logic.
module mvd_parser #(
    parameter int PENDING_WIDTH = mvd_pkg::PENDING_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic       [7:0] i_byte,
    output mvd_pkg::t_result o_res
);
    import mvd_pkg::*;

    localparam int ADD_W = LEN_ACC_W + 1;
    localparam int SUM_W = ((PENDING_WIDTH > ADD_W) ? PENDING_WIDTH : ADD_W) + 1;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_LEN,
        PH_EXT,
        PH_PAY
    } t_phase;

    t_phase                   r_phase, n_phase;
    logic [LEN_ACC_W-1:0]     r_acc, n_acc;
    logic [LEN_LEFT_W-1:0]    r_left, n_left;
    logic [SKIP_W-1:0]        r_skip, n_skip;
    logic [PENDING_WIDTH-1:0] r_pend, n_pend;
    t_kind                    r_kind, n_kind;
    logic                     r_err, n_err;

    t_tag_info                w_info;
    logic [PENDING_WIDTH-1:0] w_pend_dec;
    logic [PENDING_WIDTH-1:0] w_add_base;
    logic [ADD_W-1:0]         w_add_n;
    logic [SUM_W-1:0]         w_sum;
    logic                     w_ovf;
    logic                     w_do_add;
    logic                     w_done;
    logic [LEN_LEFT_W-1:0]    w_left_dec;
    logic [SKIP_W-1:0]        w_skip_dec;

    mvd_tag_decode u_tag_decode (
        .i_byte (i_byte),
        .o_info (w_info)
    );

    // a tag takes one pending element; none pending means a new top-level value
    assign w_pend_dec = (r_pend == '0) ? '0 : r_pend - PENDING_WIDTH'(1);
    assign w_add_base = (r_phase == PH_LEN) ? r_pend : w_pend_dec;
    assign w_left_dec = (r_left == '0) ? '0 : r_left - LEN_LEFT_W'(1);
    assign w_skip_dec = (r_skip == '0) ? '0 : r_skip - SKIP_W'(1);

    always_comb begin
        n_acc = {r_acc[LEN_ACC_W-9:0], i_byte};
        if (r_phase != PH_LEN) begin
            w_add_n = ADD_W'(w_info.cnt);
        end else if (r_kind == KIND_MAP) begin
            w_add_n = {n_acc, 1'b0};
        end else begin
            w_add_n = {1'b0, n_acc};
        end
    end

    assign w_sum = SUM_W'(w_add_base) + SUM_W'(w_add_n);
    assign w_ovf = |w_sum[SUM_W-1:PENDING_WIDTH];

    always_comb begin
        n_phase     = r_phase;
        n_left      = r_left;
        n_skip      = r_skip;
        n_pend      = r_pend;
        n_kind      = r_kind;
        n_err       = r_err;
        w_do_add    = 1'b0;
        w_done      = 1'b0;
        o_res.role  = ROLE_TAG;

        unique case (r_phase)
            PH_LEN: begin
                o_res.role = ROLE_LEN;
                n_left     = w_left_dec;
                if (w_left_dec == '0) begin
                    case (r_kind)
                        KIND_RAW: begin
                            n_skip  = n_acc;
                            n_phase = PH_PAY;
                            w_done  = (n_acc == '0);
                        end
                        KIND_EXT: begin
                            n_skip  = n_acc;
                            n_phase = PH_EXT;
                        end
                        default: w_do_add = 1'b1;
                    endcase
                end
            end
            PH_EXT: begin
                o_res.role = ROLE_EXT;
                if (r_skip == '0) begin
                    w_done = 1'b1;
                end else begin
                    n_phase = PH_PAY;
                end
            end
            PH_PAY: begin
                o_res.role = ROLE_PAY;
                n_skip     = w_skip_dec;
                w_done     = (w_skip_dec == '0);
            end
            default: begin
                o_res.role = ROLE_TAG;
                n_pend     = w_pend_dec;
                case (w_info.act)
                    ACT_DONE: w_done   = 1'b1;
                    ACT_ADD:  w_do_add = 1'b1;
                    ACT_SKIP: begin
                        n_skip  = SKIP_W'(w_info.cnt);
                        n_phase = w_info.skip_to_ext ? PH_EXT : PH_PAY;
                        w_done  = !w_info.skip_to_ext && (w_info.cnt == '0);
                    end
                    default: begin
                        n_kind  = w_info.kind;
                        n_left  = w_info.nbytes;
                        n_phase = PH_LEN;
                    end
                endcase
            end
        endcase

        if (w_do_add) begin
            if (w_ovf) begin
                n_err = 1'b1;
            end else begin
                n_pend = w_sum[PENDING_WIDTH-1:0];
                w_done = 1'b1;
            end
        end

        if (n_err || w_done) begin
            n_phase = PH_TAG;
        end

        o_res.value_end  = w_done && !n_err && (n_pend == '0);
        o_res.error_code = n_err;

        // stopped after an overflow: report the error and hold
        if (r_err) begin
            o_res.role      = ROLE_TAG;
            o_res.value_end = 1'b0;
            n_phase         = r_phase;
            n_left          = r_left;
            n_skip          = r_skip;
            n_pend          = r_pend;
            n_kind          = r_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_acc   <= '0;
            r_left  <= '0;
            r_skip  <= '0;
            r_pend  <= '0;
            r_kind  <= KIND_RAW;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_acc   <= (r_phase == PH_LEN) ? n_acc :
                       ((!r_err && r_phase == PH_TAG && w_info.act == ACT_LEN) ? '0 : r_acc);
            r_left  <= n_left;
            r_skip  <= n_skip;
            r_pend  <= n_pend;
            r_kind  <= n_kind;
            r_err   <= n_err;
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("overflow error flag cleared without reset");

    a_err_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_err) |-> (o_res.error_code && !o_res.value_end))
        else $error("byte after overflow not reported as error");

    a_len_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEN) |-> (r_left != '0))
        else $error("length phase with no length bytes left");

    a_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.value_end) |=> (r_pend == '0 && r_phase == PH_TAG))
        else $error("value end flagged with elements still pending");

endmodule

FILE: hdl/msgpack_value_delimiter.sv
// Top level of the MessagePack value delimiter: input register, parser, result register.
//
//  channel | modport              | payload                               | transaction
//  --------+----------------------+---------------------------------------+-------------------
//  i_in    | mvd_byte_if.sink     | data_byte[7:0]                        | valid & ready high
//  o_out   | mvd_result_if.source | byte_role[1:0], value_end, error_code | valid & ready high
//
//  One byte per cycle sustained while o_out is ready; a byte's result passes the input
//  register after its transaction, then the result register, and is offered on o_out from there;
//  the single-pass parser sits between the two registers.
//  Reset is synchronous, active low; it clears the handshake state and all parse state.
//  A stall on o_out holds the result register; i_in stays ready while the input
//  register is empty or moves on into the result register in the same cycle.
module msgpack_value_delimiter #(
    parameter int PENDING_WIDTH = mvd_pkg::PENDING_WIDTH_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    mvd_byte_if.sink      i_in,
    mvd_result_if.source  o_out
);
    import mvd_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_result    r_out;
    t_result    w_res;
    logic       w_adv;
    logic       w_step;

    // result register free, or being emptied this cycle
    assign w_adv      = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_in_vld || w_adv;
    // the byte in the input register is parsed as it moves into the result register
    assign w_step     = r_in_vld && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
        end
        if (w_step) begin
            r_out <= w_res;
        end
    end

    mvd_parser #(
        .PENDING_WIDTH (PENDING_WIDTH)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    assign o_out.valid      = r_out_vld;
    assign o_out.byte_role  = r_out.role;
    assign o_out.value_end  = r_out.value_end;
    assign o_out.error_code = r_out.error_code;

endmodule
